FILE: sv/ettr_pkg.sv
// ettr_pkg: shared types and constants of the edge trigger trace sampler
// no dependencies
`default_nettype none

package ettr_pkg;

  // prior level codes
  typedef enum logic [1:0] {
    LVL_LOW     = 2'd0,
    LVL_HIGH    = 2'd1,
    LVL_UNKNOWN = 2'd2,
    LVL_UNK_ALT = 2'd3
  } level_t;

  // top two bits of a received control byte
  typedef enum logic [1:0] {
    CTL_MODE     = 2'b00,
    CTL_INTERVAL = 2'b01,
    CTL_IGN_A    = 2'b10,
    CTL_IGN_B    = 2'b11
  } ctl_code_t;

  // trigger modes
  typedef enum logic [1:0] {
    TRIG_FREE     = 2'd0,
    TRIG_FREE_ALT = 2'd1,
    TRIG_STOP_RISE = 2'd2,
    TRIG_STOP_FALL = 2'd3
  } trig_t;

  localparam logic        CMD_TICK     = 1'b0;
  localparam logic [6:0]  INTERVAL_RST = 7'd100;

  localparam logic [7:0] CH_SLASH     = 8'd47;
  localparam logic [7:0] CH_DASH      = 8'd45;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_UNDER     = 8'd95;

  // one classified sample, handed from front to back
  typedef struct packed {
    logic has_edge;  // an edge symbol precedes the level symbol
    logic level;     // sampled pin level
  } sample_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

endpackage

`default_nettype wire

FILE: sv/ettr_if.sv
// ettr_in_if / ettr_out_if: valid-ready channels of the trace sampler
// depends on nothing
`default_nettype none

interface ettr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pins;
  logic [7:0] rx_byte;
  modport source (output valid, cmd, pins, rx_byte, input ready);
  modport sink   (input valid, cmd, pins, rx_byte, output ready);
endinterface

interface ettr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] trace_char;
  logic       last;
  modport source (output valid, trace_char, last, input ready);
  modport sink   (input valid, trace_char, last, output ready);
endinterface

`default_nettype wire

FILE: sv/ettr_front.sv
// ettr_front: accepts transactions, keeps mode and timing state, classifies samples
// depends on ettr_pkg and ettr_in_if
`default_nettype none

module ettr_front (
  input  wire                   clk,
  input  wire                   rst_n,
  ettr_in_if.sink               in_ch,
  input  ettr_pkg::q_stat_t     q_stat,
  output logic                  push,
  output ettr_pkg::sample_rec_t push_rec
);

  logic [2:0]       channel_r, channel_nxt;
  logic             run_r, run_nxt;
  ettr_pkg::trig_t  trig_r, trig_nxt;
  ettr_pkg::level_t prior_r, prior_nxt;
  logic [6:0]       interval_r, interval_nxt;
  logic [6:0]       countdown_r, countdown_nxt;

  logic accept;
  logic pin;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pin         = in_ch.pins[channel_r];

  always_comb begin
    channel_nxt   = channel_r;
    run_nxt       = run_r;
    trig_nxt      = trig_r;
    prior_nxt     = prior_r;
    interval_nxt  = interval_r;
    countdown_nxt = countdown_r;
    push          = 1'b0;
    push_rec      = '{has_edge: 1'b0, level: pin};
    if (accept) begin
      if (in_ch.cmd != ettr_pkg::CMD_TICK) begin
        unique case (ettr_pkg::ctl_code_t'(in_ch.rx_byte[7:6]))
          ettr_pkg::CTL_MODE: begin
            channel_nxt = in_ch.rx_byte[2:0];
            run_nxt     = in_ch.rx_byte[3];
            trig_nxt    = ettr_pkg::trig_t'(in_ch.rx_byte[5:4]);
            prior_nxt   = ettr_pkg::LVL_UNKNOWN;
          end
          ettr_pkg::CTL_INTERVAL: begin
            interval_nxt = {1'b0, in_ch.rx_byte[5:0]};
          end
          default: begin
          end
        endcase
      end else if (countdown_r != 7'd0) begin
        countdown_nxt = countdown_r - 7'd1;
      end else if (run_r) begin
        push          = 1'b1;
        countdown_nxt = interval_r;
        if (pin) begin
          prior_nxt = ettr_pkg::LVL_HIGH;
          if (prior_r == ettr_pkg::LVL_LOW) begin
            push_rec.has_edge = 1'b1;
            if (trig_r == ettr_pkg::TRIG_STOP_RISE) run_nxt = 1'b0;
          end
        end else begin
          prior_nxt = ettr_pkg::LVL_LOW;
          if (prior_r == ettr_pkg::LVL_HIGH) begin
            push_rec.has_edge = 1'b1;
            if (trig_r == ettr_pkg::TRIG_STOP_FALL) run_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r   <= 3'd0;
      run_r       <= 1'b1;
      trig_r      <= ettr_pkg::TRIG_FREE;
      prior_r     <= ettr_pkg::LVL_UNKNOWN;
      interval_r  <= ettr_pkg::INTERVAL_RST;
      countdown_r <= 7'd0;
    end else begin
      channel_r   <= channel_nxt;
      run_r       <= run_nxt;
      trig_r      <= trig_nxt;
      prior_r     <= prior_nxt;
      interval_r  <= interval_nxt;
      countdown_r <= countdown_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ettr_queue.sv
// ettr_queue: short queue of classified samples between front and back
// depends on ettr_pkg
`default_nettype none

module ettr_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  ettr_pkg::sample_rec_t push_rec,
  input  wire                   pop,
  output ettr_pkg::sample_rec_t head,
  output ettr_pkg::q_stat_t     q_stat
);

  ettr_pkg::sample_rec_t         mem [ettr_pkg::QDEPTH];
  logic [ettr_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ettr_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ettr_pkg::QAW:0]        count_r, count_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (count_r == (ettr_pkg::QAW + 1)'(ettr_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ettr_back.sv
// ettr_back: turns queued samples into trace symbols on the output register
// depends on ettr_pkg and ettr_out_if
`default_nettype none

module ettr_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ettr_pkg::sample_rec_t head,
  input  ettr_pkg::q_stat_t     q_stat,
  output logic                  pop,
  ettr_out_if.source            out_ch
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       edge_done_r, edge_done_nxt;
  logic       load;

  assign load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt     = valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    edge_done_nxt = edge_done_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (head.has_edge && !edge_done_r) begin
          // edge symbol first, level symbol on the next load
          char_nxt      = head.level ? ettr_pkg::CH_SLASH : ettr_pkg::CH_BACKSLASH;
          last_nxt      = 1'b0;
          edge_done_nxt = 1'b1;
        end else begin
          char_nxt      = head.level ? ettr_pkg::CH_DASH : ettr_pkg::CH_UNDER;
          last_nxt      = 1'b1;
          edge_done_nxt = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      edge_done_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      edge_done_r <= edge_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.trace_char = char_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

FILE: sv/edge_trigger_trace_sampler_top.sv
// edge_trigger_trace_sampler_top: single-channel logic trace sampler
// a sampled tick goes through the sample queue and then the output register
// throughput: one input transaction per cycle while the four-entry sample queue has room;
//   one symbol per cycle out while the sink is ready; an edge sample yields two symbols
// ticks and control bytes that produce no symbol never enter the queue
// reset (synchronous, active low): channel 0, running, free mode, level unknown, interval 100
`default_nettype none

module edge_trigger_trace_sampler_top (
  input  wire         clk,
  input  wire         rst_n,
  ettr_in_if.sink     in_ch,
  ettr_out_if.source  out_ch
);

  // front to queue
  logic                  push;
  ettr_pkg::sample_rec_t push_rec;
  // queue to back
  ettr_pkg::sample_rec_t head;
  ettr_pkg::q_stat_t     q_stat;
  logic                  pop;

  // front: decodes control bytes, runs the countdown, classifies each sample
  ettr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  // queue decouples sampling from output stalls
  ettr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: emits the edge symbol, if any, then the level symbol through the output register
  ettr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // the front only pushes when the queue has room
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("sample pushed into full queue");

  // an edge symbol never ends a sample
  a_edge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.trace_char == ettr_pkg::CH_SLASH ||
                      out_ch.trace_char == ettr_pkg::CH_BACKSLASH)) |-> !out_ch.last)
    else $error("edge symbol flagged last");

  // once an edge symbol is taken, its level symbol follows right away
  a_level_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> (out_ch.valid && out_ch.last))
    else $error("level symbol missing after edge symbol");

  // popping only happens on a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
